// ===== src/rbqs_pkg.sv =====
// package for the ready/blocked queue scheduler
// holds queue sizing, event and command codes, sequencer states and index helpers
// no dependencies
package rbqs_pkg;

	// queue sizing
	localparam int MAX_PROCS = 16;
	localparam int IDX_W     = (MAX_PROCS > 2) ? $clog2(MAX_PROCS) : 1;
	localparam int CNT_W     = $clog2(MAX_PROCS + 1);
	localparam int PID_W     = 8;
	localparam int EV_W      = 4;
	localparam int LVL_W     = 5;

	// command codes
	localparam logic CMD_CREATE = 1'b0;
	localparam logic CMD_STEP   = 1'b1;

	// run outcome codes (anything else blocks)
	localparam logic [1:0] RUN_EXIT    = 2'd0;
	localparam logic [1:0] RUN_SUSPEND = 2'd1;

	// wake outcome codes
	localparam logic WAKE_UNBLOCK = 1'b1;

	// event codes
	localparam logic [EV_W-1:0] EV_CREATED       = 4'd0;
	localparam logic [EV_W-1:0] EV_REJECTED      = 4'd1;
	localparam logic [EV_W-1:0] EV_EXITED        = 4'd2;
	localparam logic [EV_W-1:0] EV_SUSPENDED     = 4'd3;
	localparam logic [EV_W-1:0] EV_BLOCKED       = 4'd4;
	localparam logic [EV_W-1:0] EV_READY_EMPTY   = 4'd5;
	localparam logic [EV_W-1:0] EV_STILL_BLOCKED = 4'd6;
	localparam logic [EV_W-1:0] EV_UNBLOCKED     = 4'd7;
	localparam logic [EV_W-1:0] EV_IDLE          = 4'd8;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_EMPTY,
		ST_WAKE,
		ST_FIN
	} state_t;

	// next slot after idx, wrapping at the queue size
	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] res;
		if (idx == IDX_W'(MAX_PROCS - 1)) res = '0;
		else res = idx + IDX_W'(1);
		return res;
	endfunction

	// slot behind the last entry: (head + count) mod size, the sum stays below twice the size
	function automatic logic [IDX_W-1:0] idx_tail(input logic [IDX_W-1:0] head,
			input logic [CNT_W-1:0] cnt);
		logic [CNT_W+1:0] sum;
		sum = (CNT_W+2)'(head) + (CNT_W+2)'(cnt);
		if (sum >= (CNT_W+2)'(MAX_PROCS)) sum = sum - (CNT_W+2)'(MAX_PROCS);
		return IDX_W'(sum);
	endfunction

endpackage

// ===== src/ready_blocked_queue_scheduler_top.sv =====
// top level of the ready/blocked queue scheduler
// two pid queues in register arrays, one shared tail index unit, a small sequencer
// depends on rbqs_pkg
//
// channel  | dir | tdata                                      | tuser       | tlast
// s_axis   | in  | pid[7:0] run_outcome[9:8] wake_outcome[10] | cmd         | -
// m_axis   | out | proc_id[7:0] ready_level[12:8]             | event_res   | last
//          |     | blocked_level[17:13]                       |             |
//
// a word is taken while the sequencer is idle, then each result comes from its own state (create: 1, step: 1 to 3),
// and a step that finds ready empty before dispatch first passes silently into ST_EMPTY
// the sequencer pace is set by the single tail index unit and one queue write per cycle
// s_axis_tready is high only while the sequencer is idle
// each result waits in the output register; a stalled m_axis holds the sequencer
// reset clears the heads, counts, sequencer and output valid; queue slots are not cleared
module ready_blocked_queue_scheduler_top import rbqs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // pid[7:0], run_outcome[9:8], wake_outcome[10], zeros
	input  logic        s_axis_tuser,  // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // proc_id[7:0], ready_level[12:8], blocked_level[17:13], zeros
	output logic [3:0]  m_axis_tuser,  // event_res
	output logic        m_axis_tlast
);

	state_t state_q, state_d;

	// latched input word
	logic             cmd_q;
	logic [PID_W-1:0] pid_q;
	logic [1:0]       run_q;
	logic             wake_q;

	// queues
	logic [PID_W-1:0] rd_mem [MAX_PROCS];
	logic [PID_W-1:0] bl_mem [MAX_PROCS];
	logic [IDX_W-1:0] rd_head_q, rd_head_d, bl_head_q, bl_head_d;
	logic [CNT_W-1:0] rd_cnt_q, rd_cnt_d, bl_cnt_q, bl_cnt_d;

	// queue write port
	logic             rd_we, bl_we;
	logic [PID_W-1:0] wr_data;

	// shared tail index unit
	logic             tu_sel_bl;
	logic [IDX_W-1:0] tail_idx;

	// output register
	logic             out_valid_q;
	logic [EV_W-1:0]  out_ev_q, ev_d;
	logic [PID_W-1:0] out_id_q, id_d;
	logic [LVL_W-1:0] out_rl_q, out_bl_q;
	logic             out_last_q, last_d, out_load;

	logic             s_acc, can_emit, rd_full, bl_full, do_block, do_unblock;
	logic [PID_W-1:0] rd_top, bl_top;

	assign s_acc    = s_axis_tvalid && s_axis_tready;
	assign can_emit = !out_valid_q || m_axis_tready;
	assign rd_full  = (rd_cnt_q == CNT_W'(MAX_PROCS));
	assign bl_full  = (bl_cnt_q == CNT_W'(MAX_PROCS));
	assign rd_top   = rd_mem[rd_head_q];
	assign bl_top   = bl_mem[bl_head_q];

	// run outcome three is treated as block; a full blocked queue turns block into suspend
	assign do_block   = (run_q != RUN_EXIT) && (run_q != RUN_SUSPEND) && !bl_full;
	assign do_unblock = (wake_q == WAKE_UNBLOCK) && !rd_full;

	// tail index of the selected queue
	assign tail_idx = tu_sel_bl ? idx_tail(bl_head_q, bl_cnt_q) : idx_tail(rd_head_q, rd_cnt_q);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// next state, queue updates and result
	always_comb begin
		state_d   = state_q;
		tu_sel_bl = 1'b0;
		rd_we     = 1'b0;
		bl_we     = 1'b0;
		wr_data   = pid_q;
		rd_head_d = rd_head_q;
		rd_cnt_d  = rd_cnt_q;
		bl_head_d = bl_head_q;
		bl_cnt_d  = bl_cnt_q;
		out_load  = 1'b0;
		ev_d      = EV_IDLE;
		id_d      = '0;
		last_d    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_acc) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (cmd_q == CMD_CREATE) begin
					if (can_emit) begin
						out_load = 1'b1;
						id_d     = pid_q;
						last_d   = 1'b1;
						state_d  = ST_IDLE;
						if (rd_full) begin
							ev_d = EV_REJECTED;
						end else begin
							ev_d     = EV_CREATED;
							rd_we    = 1'b1;
							rd_cnt_d = rd_cnt_q + CNT_W'(1);
						end
					end
				end else if (rd_cnt_q == '0 && bl_cnt_q == '0) begin
					if (can_emit) begin
						out_load = 1'b1;
						ev_d     = EV_IDLE;
						last_d   = 1'b1;
						state_d  = ST_IDLE;
					end
				end else if (rd_cnt_q == '0) begin
					state_d = ST_EMPTY;
				end else if (can_emit) begin
					// dispatch the ready head
					out_load  = 1'b1;
					id_d      = rd_top;
					wr_data   = rd_top;
					rd_head_d = idx_inc(rd_head_q);
					if (run_q == RUN_EXIT) begin
						ev_d     = EV_EXITED;
						rd_cnt_d = rd_cnt_q - CNT_W'(1);
					end else if (do_block) begin
						ev_d      = EV_BLOCKED;
						tu_sel_bl = 1'b1;
						bl_we     = 1'b1;
						rd_cnt_d  = rd_cnt_q - CNT_W'(1);
						bl_cnt_d  = bl_cnt_q + CNT_W'(1);
					end else begin
						ev_d  = EV_SUSPENDED;
						rd_we = 1'b1;
					end
					// more results follow if ready ran dry or a blocked pid waits
					if (rd_cnt_d == '0) state_d = ST_EMPTY;
					else if (bl_cnt_d != '0) state_d = ST_WAKE;
					else begin
						last_d  = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMPTY: begin
				if (can_emit) begin
					out_load = 1'b1;
					ev_d     = EV_READY_EMPTY;
					state_d  = (bl_cnt_q != '0) ? ST_WAKE : ST_FIN;
				end
			end
			ST_WAKE: begin
				// total occupancy stays non-zero, so this is always the final result
				if (can_emit) begin
					out_load  = 1'b1;
					id_d      = bl_top;
					wr_data   = bl_top;
					last_d    = 1'b1;
					state_d   = ST_IDLE;
					bl_head_d = idx_inc(bl_head_q);
					if (do_unblock) begin
						ev_d     = EV_UNBLOCKED;
						rd_we    = 1'b1;
						rd_cnt_d = rd_cnt_q + CNT_W'(1);
						bl_cnt_d = bl_cnt_q - CNT_W'(1);
					end else begin
						ev_d      = EV_STILL_BLOCKED;
						tu_sel_bl = 1'b1;
						bl_we     = 1'b1;
					end
				end
			end
			ST_FIN: begin
				if (can_emit) begin
					out_load = 1'b1;
					ev_d     = EV_IDLE;
					last_d   = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// input word capture
	always_ff @(posedge clk) begin
		if (s_acc) begin
			cmd_q  <= s_axis_tuser;
			pid_q  <= s_axis_tdata[7:0];
			run_q  <= s_axis_tdata[9:8];
			wake_q <= s_axis_tdata[10];
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (rd_we) rd_mem[tail_idx] <= wr_data;
		if (bl_we) bl_mem[tail_idx] <= wr_data;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_head_q <= '0;
			rd_cnt_q  <= '0;
			bl_head_q <= '0;
			bl_cnt_q  <= '0;
		end else begin
			rd_head_q <= rd_head_d;
			rd_cnt_q  <= rd_cnt_d;
			bl_head_q <= bl_head_d;
			bl_cnt_q  <= bl_cnt_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (m_axis_tready) out_valid_q <= 1'b0;
	end

	// output register payload, levels taken after the update
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ev_q   <= ev_d;
			out_id_q   <= id_d;
			out_rl_q   <= LVL_W'(rd_cnt_d);
			out_bl_q   <= LVL_W'(bl_cnt_d);
			out_last_q <= last_d;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_ev_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {6'd0, out_bl_q, out_rl_q, out_id_q};

endmodule

// ===== src/rbqs_checker.sv =====
// port checker for the ready/blocked queue scheduler, bound to the top level
// depends on rbqs_pkg and ready_blocked_queue_scheduler_top
module rbqs_checker import rbqs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [3:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result word changed");

	// one word at a time: no new word right after one is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while previous word in progress");

	// create results close the run
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == EV_CREATED || m_axis_tuser == EV_REJECTED)
			|-> m_axis_tlast)
		else $error("create result without tlast");

	// ready empty notice: no pid, empty ready level, more results follow
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == EV_READY_EMPTY
			|-> m_axis_tdata[7:0] == 8'd0 && m_axis_tdata[12:8] == 5'd0 && !m_axis_tlast)
		else $error("bad ready empty notice");

	// idle notice: both queues empty and final
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == EV_IDLE
			|-> m_axis_tdata[17:8] == 10'd0 && m_axis_tdata[7:0] == 8'd0 && m_axis_tlast)
		else $error("bad idle notice");

endmodule

bind ready_blocked_queue_scheduler_top rbqs_checker u_rbqs_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for the ready/blocked queue scheduler: directed words, then mixed random runs
// keeps its own copy of both pid queues in a small scoreboard class; depends on rbqs_pkg
module tb import rbqs_pkg::*; ();

	// run outcome codes that the package leaves unnamed
	localparam logic [1:0] RUN_BLOCK     = 2'd2;
	localparam logic [1:0] RUN_BLOCK_ALT = 2'd3;  // behaves as block
	localparam logic       WAKE_STAY     = 1'b0;
	localparam int         CYCLE_LIMIT   = 200000;
	localparam int         HOLD_CYCLES   = 300;

	// one result word as the block reports it
	typedef struct packed {
		logic [EV_W-1:0]  code;
		logic [PID_W-1:0] pid;
		logic [LVL_W-1:0] ready_lvl;
		logic [LVL_W-1:0] blocked_lvl;
		logic             last;
	} sched_event_t;

	// stimulus flavours that push the queues towards their corners
	typedef enum int {MODE_FILL, MODE_BLOCK, MODE_WAKE, MODE_DRAIN, MODE_MIX} mix_mode_t;

	// tracks both pid queues and the events each accepted word should produce
	class sched_scoreboard;
		logic [PID_W-1:0] ready_pids[$];
		logic [PID_W-1:0] blocked_pids[$];
		sched_event_t     pending_events[$];
		sched_event_t     word_events[$];
		int               fails;
		int               results_seen;

		function int pending();
			return pending_events.size();
		endfunction

		// queue an event with the occupancy as it stands now
		function void add_event(logic [EV_W-1:0] code, logic [PID_W-1:0] pid);
			sched_event_t e;
			e.code        = code;
			e.pid         = pid;
			e.ready_lvl   = LVL_W'(ready_pids.size());
			e.blocked_lvl = LVL_W'(blocked_pids.size());
			e.last        = 1'b0;
			word_events.push_back(e);
		endfunction

		// work out the events of one accepted input word
		function void note_command(logic cmd, logic [PID_W-1:0] pid, logic [1:0] run, logic wake);
			logic [PID_W-1:0] p;
			sched_event_t     tail;
			word_events.delete();
			if (cmd == CMD_CREATE) begin
				if (ready_pids.size() >= MAX_PROCS) begin
					add_event(EV_REJECTED, pid);
				end else begin
					ready_pids.push_back(pid);
					add_event(EV_CREATED, pid);
				end
			end else if (ready_pids.size() == 0 && blocked_pids.size() == 0) begin
				add_event(EV_IDLE, '0);
			end else begin
				// dispatch the ready head
				if (ready_pids.size() != 0) begin
					p = ready_pids.pop_front();
					if (run == RUN_EXIT) begin
						add_event(EV_EXITED, p);
					end else if (run == RUN_SUSPEND || blocked_pids.size() >= MAX_PROCS) begin
						ready_pids.push_back(p);
						add_event(EV_SUSPENDED, p);
					end else begin
						blocked_pids.push_back(p);
						add_event(EV_BLOCKED, p);
					end
				end
				if (ready_pids.size() == 0)
					add_event(EV_READY_EMPTY, '0);
				// blocked head either wakes or goes round again
				if (blocked_pids.size() != 0) begin
					p = blocked_pids.pop_front();
					if (wake == WAKE_UNBLOCK && ready_pids.size() < MAX_PROCS) begin
						ready_pids.push_back(p);
						add_event(EV_UNBLOCKED, p);
					end else begin
						blocked_pids.push_back(p);
						add_event(EV_STILL_BLOCKED, p);
					end
				end
				if (ready_pids.size() == 0 && blocked_pids.size() == 0)
					add_event(EV_IDLE, '0);
			end
			tail = word_events.pop_back();
			tail.last = 1'b1;
			word_events.push_back(tail);
			foreach (word_events[i])
				pending_events.push_back(word_events[i]);
		endfunction

		task report(string what);
			fails++;
			$display("result %0d: %s", results_seen, what);
		endtask

		// compare one result word with the oldest expectation
		task check_event(sched_event_t got);
			sched_event_t want;
			results_seen++;
			if (pending_events.size() == 0) begin
				report($sformatf("unexpected word, event %0d pid %0d", got.code, got.pid));
				return;
			end
			want = pending_events.pop_front();
			if (got.code !== want.code)
				report($sformatf("event got %0d want %0d", got.code, want.code));
			if (got.pid !== want.pid)
				report($sformatf("proc_id got %0d want %0d", got.pid, want.pid));
			if (got.ready_lvl !== want.ready_lvl)
				report($sformatf("ready level got %0d want %0d", got.ready_lvl, want.ready_lvl));
			if (got.blocked_lvl !== want.blocked_lvl)
				report($sformatf("blocked level got %0d want %0d",
					got.blocked_lvl, want.blocked_lvl));
			if (got.last !== want.last)
				report($sformatf("last got %0b want %0b", got.last, want.last));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;
	logic        m_axis_tlast;

	sched_scoreboard sb;
	int              cycles;
	int              burst_left;
	bit              hold_off_req;

	ready_blocked_queue_scheduler_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_event('{code: m_axis_tuser, pid: m_axis_tdata[7:0],
				ready_lvl: m_axis_tdata[12:8], blocked_lvl: m_axis_tdata[17:13],
				last: m_axis_tlast});
	end

	// receiver: stall patterns in segments, one long hold-off on request
	initial begin
		int seg_left;
		int stall_kind;
		int hold_left;
		seg_left   = 0;
		stall_kind = 0;
		hold_left  = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					seg_left   = $urandom_range(10, 80);
					stall_kind = $urandom_range(0, 3);
				end
				seg_left--;
				case (stall_kind)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= (cycles % 3 != 0);
				endcase
			end
		end
	end

	// offer one word, called at a falling edge; returns at a falling edge
	task automatic offer(logic cmd, logic [PID_W-1:0] pid, logic [1:0] run, logic wake);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {5'b0, wake, run, pid};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_command(cmd, pid, run, wake);
		@(negedge clk);
		// burst bookkeeping: sometimes back to back, sometimes a gap
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// one random word shaped by the current flavour
	task automatic random_word(mix_mode_t mode);
		logic             cmd;
		logic [PID_W-1:0] pid;
		logic [1:0]       run;
		logic             wake;
		pid  = PID_W'($urandom_range(0, 255));
		run  = 2'($urandom_range(0, 3));
		wake = 1'($urandom_range(0, 1));
		case (mode)
			MODE_FILL: cmd = ($urandom_range(0, 99) < 85) ? CMD_CREATE : CMD_STEP;
			MODE_BLOCK: begin
				cmd  = $urandom_range(0, 1) ? CMD_STEP : CMD_CREATE;
				run  = $urandom_range(0, 1) ? RUN_BLOCK : RUN_BLOCK_ALT;
				wake = WAKE_STAY;
			end
			MODE_WAKE: begin
				cmd  = ($urandom_range(0, 99) < 40) ? CMD_CREATE : CMD_STEP;
				run  = RUN_SUSPEND;
				wake = WAKE_UNBLOCK;
			end
			MODE_DRAIN: begin
				cmd = ($urandom_range(0, 99) < 10) ? CMD_CREATE : CMD_STEP;
				run = RUN_EXIT;
			end
			default: cmd = $urandom_range(0, 1) ? CMD_STEP : CMD_CREATE;
		endcase
		offer(cmd, pid, run, wake);
	endtask

	// main sequence
	initial begin
		mix_mode_t schedule[12];
		sb = new();
		cycles        = 0;
		burst_left    = 4;
		hold_off_req  = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser  = CMD_CREATE;
		s_axis_tdata  = '0;
		schedule = '{MODE_FILL, MODE_BLOCK, MODE_BLOCK, MODE_FILL, MODE_WAKE, MODE_DRAIN,
			MODE_DRAIN, MODE_MIX, MODE_FILL, MODE_BLOCK, MODE_WAKE, MODE_DRAIN};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty step, extreme pids, every outcome, three-result steps
		offer(CMD_STEP, 8'h00, RUN_EXIT, WAKE_STAY);
		offer(CMD_CREATE, 8'h00, RUN_EXIT, WAKE_STAY);
		offer(CMD_CREATE, 8'hFF, RUN_EXIT, WAKE_STAY);
		offer(CMD_STEP, 8'h00, RUN_EXIT, WAKE_STAY);
		offer(CMD_STEP, 8'h00, RUN_BLOCK, WAKE_UNBLOCK);
		offer(CMD_STEP, 8'hFF, RUN_BLOCK_ALT, WAKE_STAY);
		offer(CMD_STEP, 8'h00, RUN_SUSPEND, WAKE_STAY);
		offer(CMD_STEP, 8'h00, RUN_SUSPEND, WAKE_UNBLOCK);
		offer(CMD_STEP, 8'h00, RUN_EXIT, WAKE_STAY);
		// fill the ready queue up to rejection
		for (int i = 0; i < MAX_PROCS; i++)
			offer(CMD_CREATE, PID_W'(i * 17 + 3), RUN_EXIT, WAKE_STAY);
		offer(CMD_CREATE, 8'hC3, RUN_EXIT, WAKE_STAY);
		offer(CMD_STEP, 8'h3C, RUN_SUSPEND, WAKE_UNBLOCK);

		// random part, with one long receiver hold-off early on
		hold_off_req = 1'b1;
		foreach (schedule[b])
			repeat (33) random_word(schedule[b]);

		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.fails == 0 && sb.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/rbqs_pkg.sv
src/ready_blocked_queue_scheduler_top.sv
src/rbqs_checker.sv
tb/tb.sv
